// ===== hdl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the provisioning RPC frame checker
// Parse phases, result kinds, status codes and the request that travels from
// the front part to the back part through the queue.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int PFC_FIFO_DEPTH = 4;

	localparam logic [7:0] CMD_SEND_WIFI = 8'h01;
	localparam logic [1:0] MIN_OCTETS    = 2'd2;
	localparam logic [1:0] COUNT_SAT     = 2'd3;

	typedef enum logic [2:0] {
		PH_CMD      = 3'd0,
		PH_LEN      = 3'd1,
		PH_NAME_LEN = 3'd2,
		PH_NAME     = 3'd3,
		PH_PASS_LEN = 3'd4,
		PH_PASS     = 3'd5,
		PH_DONE     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NAME   = 2'd0,
		KIND_PASS   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	// one request: an optional field octet followed by an optional status
	typedef struct packed {
		logic    fld_vld;
		kind_t   fld_kind;
		logic [7:0] fld_octet;
		logic    sts_vld;
		status_t sts_code;
	} req_t;

endpackage

// ===== hdl/pfc_front.sv =====
// ----------------------------------------------------------------------------
// pfc_front: octet intake and frame parser
// Holds each octet back one item, walks the frame phases with the held octet,
// and issues field and status requests to the queue.
// ----------------------------------------------------------------------------
module pfc_front import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_octet,
	input  logic       end_of_packet,
	input  logic       q_full,
	output logic       q_wr,
	output req_t       q_req
);

	phase_t     phase_q, phase_p;
	logic [7:0] remain_q, remain_p;
	logic [7:0] sum_q, sum_p;
	logic [7:0] held_q;
	logic       held_vld_q;
	logic [1:0] count_q, count_p;
	logic [7:0] cmd_q, cmd_p;
	logic       acc, proc;
	req_t       req;

	assign full = q_full;
	assign acc  = push && !q_full;
	assign proc = acc && held_vld_q;

	// next state after processing the held octet
	always_comb begin
		phase_p  = phase_q;
		remain_p = remain_q;
		sum_p    = sum_q;
		count_p  = count_q;
		cmd_p    = cmd_q;
		if (proc) begin
			sum_p = sum_q + held_q;
			if (count_q != COUNT_SAT) begin
				count_p = count_q + 2'd1;
			end
			case (phase_q)
				PH_CMD: begin
					cmd_p   = held_q;
					phase_p = PH_LEN;
				end
				PH_LEN: begin
					phase_p = PH_NAME_LEN;
				end
				PH_NAME_LEN: begin
					remain_p = held_q;
					phase_p  = (held_q == 8'd0) ? PH_PASS_LEN : PH_NAME;
				end
				PH_NAME: begin
					remain_p = remain_q - 8'd1;
					if (remain_q == 8'd1) begin
						phase_p = PH_PASS_LEN;
					end
				end
				PH_PASS_LEN: begin
					remain_p = held_q;
					phase_p  = (held_q == 8'd0) ? PH_DONE : PH_PASS;
				end
				PH_PASS: begin
					remain_p = remain_q - 8'd1;
					if (remain_q == 8'd1) begin
						phase_p = PH_DONE;
					end
				end
				default: begin
					phase_p = PH_DONE;
				end
			endcase
		end
	end

	// request contents
	always_comb begin
		req           = '0;
		req.fld_kind  = (phase_q == PH_PASS) ? KIND_PASS : KIND_NAME;
		req.fld_octet = held_q;
		req.fld_vld   = proc && (phase_q inside {PH_NAME, PH_PASS})
		                && (cmd_q == CMD_SEND_WIFI);
		req.sts_vld   = acc && end_of_packet;
		if (count_p < MIN_OCTETS) begin
			req.sts_code = ST_INVALID;
		end else if (sum_p != in_octet) begin
			req.sts_code = ST_INVALID;
		end else if (cmd_p != CMD_SEND_WIFI) begin
			req.sts_code = ST_UNKNOWN;
		end else if (phase_p != PH_DONE) begin
			req.sts_code = ST_INVALID;
		end else begin
			req.sts_code = ST_OK;
		end
	end

	assign q_wr  = req.fld_vld || req.sts_vld;
	assign q_req = req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CMD;
			remain_q   <= '0;
			sum_q      <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
			count_q    <= '0;
			cmd_q      <= '0;
		end else if (acc) begin
			if (end_of_packet) begin
				// frame closed: drop all frame state
				phase_q    <= PH_CMD;
				remain_q   <= '0;
				sum_q      <= '0;
				held_q     <= '0;
				held_vld_q <= 1'b0;
				count_q    <= '0;
				cmd_q      <= '0;
			end else begin
				phase_q    <= phase_p;
				remain_q   <= remain_p;
				sum_q      <= sum_p;
				held_q     <= in_octet;
				held_vld_q <= 1'b1;
				count_q    <= count_p;
				cmd_q      <= cmd_p;
			end
		end
	end

endmodule

// ===== hdl/pfc_fifo.sv =====
// ----------------------------------------------------------------------------
// pfc_fifo: request queue between front and back
// Small register queue; one write per cycle unless full, one read unless empty.
// ----------------------------------------------------------------------------
module pfc_fifo import pfc_pkg::*; #(
	parameter int DEPTH = PFC_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  req_t wr_data,
	output logic full,
	input  logic rd,
	output req_t rd_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/pfc_back.sv =====
// ----------------------------------------------------------------------------
// pfc_back: result sequencer
// Takes requests from the queue and delivers their field and status results
// one per cycle through the output register while it is free or popped.
// ----------------------------------------------------------------------------
module pfc_back import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  req_t       q_data,
	output logic       q_rd,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] item_kind,
	output logic [7:0] payload_octet,
	output logic [1:0] frame_status,
	output logic       run_end
);

	req_t       stg_q;
	logic       stg_vld_q;
	logic       out_vld_q;
	kind_t      kind_q;
	logic [7:0] octet_q;
	status_t    status_q;
	logic       last_q;
	logic       slot_free, emit, emit_fld, stg_done;

	assign slot_free = !out_vld_q || pop;
	assign emit      = stg_vld_q && slot_free;
	assign emit_fld  = emit && stg_q.fld_vld;
	assign stg_done  = emit && (!stg_q.fld_vld || !stg_q.sts_vld);
	assign q_rd      = !q_empty && (!stg_vld_q || stg_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (q_rd) begin
				stg_vld_q <= 1'b1;
			end else if (stg_done) begin
				stg_vld_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			stg_q <= q_data;
		end else if (emit_fld) begin
			// field sent; a pending status stays staged
			stg_q.fld_vld <= 1'b0;
		end
		if (emit) begin
			if (stg_q.fld_vld) begin
				kind_q   <= stg_q.fld_kind;
				octet_q  <= stg_q.fld_octet;
				status_q <= ST_OK;
				last_q   <= !stg_q.sts_vld;
			end else begin
				kind_q   <= KIND_STATUS;
				octet_q  <= '0;
				status_q <= stg_q.sts_code;
				last_q   <= 1'b1;
			end
		end
	end

	assign empty         = !out_vld_q;
	assign item_kind     = kind_q;
	assign payload_octet = octet_q;
	assign frame_status  = status_q;
	assign run_end       = last_q;

	a_field_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q != KIND_STATUS) |-> (status_q == ST_OK))
		else $error("field result carries a nonzero status");

	a_status_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q == KIND_STATUS) |-> (last_q && octet_q == 8'd0))
		else $error("status result must end its run with a zero octet");

	a_staging_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && !stg_vld_q) |=> stg_vld_q)
		else $error("staging register did not take a waiting request");

	a_no_read_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("request read from an empty queue");

endmodule

// ===== hdl/provisioning_rpc_frame_checker.sv =====
// ----------------------------------------------------------------------------
// provisioning_rpc_frame_checker: provisioning command frame checker
// Octet-per-item parser for the send-network-settings command frame.
// ----------------------------------------------------------------------------
// Path: each request passes the queue write, the staging register and the output
//   register before its results show.
// Throughput: one octet per cycle while the queue is not full; an octet that
//   causes two results sends both in turn, the queue absorbs the difference.
// Reset: arst_n clears the parse state, the queue pointers and count, and the staging and output valid flags.
module provisioning_rpc_frame_checker import pfc_pkg::*; #(
	parameter int FIFO_DEPTH = PFC_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_octet,
	input  logic       end_of_packet,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] item_kind,
	output logic [7:0] payload_octet,
	output logic [1:0] frame_status,
	output logic       run_end
);

	logic q_wr, q_full, q_rd, q_empty;
	req_t q_wr_data, q_rd_data;

	pfc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.in_octet      (in_octet),
		.end_of_packet (end_of_packet),
		.q_full        (q_full),
		.q_wr          (q_wr),
		.q_req         (q_wr_data)
	);

	pfc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	pfc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (q_rd_data),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.item_kind     (item_kind),
		.payload_octet (payload_octet),
		.frame_status  (frame_status),
		.run_end       (run_end)
	);

endmodule
